### design/spt_pkg.sv
package spt_pkg;

  // Table and datapath sizes
  localparam int MAX_CLASSIFIERS = 16384;
  localparam int WEIGHT_BITS     = 48;
  localparam int FEATURE_BITS    = 24;
  localparam int INDEX_BITS      = 14;
  localparam int RATE_BITS       = 24;
  localparam int THRESH_BITS     = 47;
  localparam int COUNT_BITS      = 15;
  localparam int MAX_OUT_BITS    = 47;

  // Configuration port
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 47;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_LEARNING_RATE    = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_STOP_THRESHOLD   = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CLASSIFIER_COUNT = 2'd2;

  localparam logic [RATE_BITS-1:0]   RATE_RESET   = 24'd16777;     // ~0.001 in Q0.24
  localparam logic [THRESH_BITS-1:0] THRESH_RESET = 47'd1678;      // ~0.0001 in Q24.24
  localparam logic [COUNT_BITS-1:0]  COUNT_RESET  = 15'd16384;

  // 1.0 in Q24.24
  localparam logic [WEIGHT_BITS-1:0] SLOPE_RESET  = 48'd16777216;

  // Front-to-back queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [INDEX_BITS-1:0]          idx;
    logic signed [FEATURE_BITS-1:0] feature;
    logic                           label;
    logic                           last;
    logic                           in_use;
  } item_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_SUM,
    B_SIGN,
    B_UPD,
    B_FIN
  } back_state_t;

  typedef struct packed {
    logic clearing;
    logic stopped;
  } back_status_t;

endpackage

### design/spt_front.sv
module spt_front #(
  parameter int MAX_CLASSIFIERS = spt_pkg::MAX_CLASSIFIERS
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    start,
  output logic                                    busy,
  input  logic [spt_pkg::INDEX_BITS-1:0]          in_classifier_index,
  input  logic signed [spt_pkg::FEATURE_BITS-1:0] in_feature_value,
  input  logic                                    in_sample_label,
  input  logic                                    in_last_of_sample,
  input  logic [spt_pkg::COUNT_BITS-1:0]          classifier_count,
  input  logic                                    table_busy,
  input  logic                                    pop,
  output spt_pkg::item_t                          head,
  output logic                                    q_empty
);

  localparam int PW = spt_pkg::QPTR_BITS;
  localparam int CW = spt_pkg::QPTR_BITS + 1;

  spt_pkg::item_t q_r [spt_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  cnt_r;
  logic           q_full, push, in_use;
  spt_pkg::item_t item;

  assign q_full  = (cnt_r == CW'(spt_pkg::QUEUE_DEPTH));
  assign q_empty = (cnt_r == '0);
  assign busy    = table_busy | q_full;
  assign push    = start & ~busy;

  // entry is live only below both the programmed count and the table depth
  assign in_use = ({1'b0, in_classifier_index} < classifier_count) &&
                  (int'(in_classifier_index) < MAX_CLASSIFIERS);

  always_comb begin
    item.idx     = in_classifier_index;
    item.feature = in_feature_value;
    item.label   = in_sample_label;
    item.last    = in_last_of_sample;
    item.in_use  = in_use;
  end

  assign head = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

### design/spt_back.sv
module spt_back #(
  parameter int MAX_CLASSIFIERS = spt_pkg::MAX_CLASSIFIERS
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  spt_pkg::item_t                          head,
  input  logic                                    q_empty,
  output logic                                    pop,
  input  logic [spt_pkg::RATE_BITS-1:0]           learning_rate,
  input  logic [spt_pkg::THRESH_BITS-1:0]         stop_threshold,
  output spt_pkg::back_status_t                   status,
  output logic                                    res_valid,
  output logic                                    res_prediction,
  output logic signed [spt_pkg::WEIGHT_BITS-1:0]  res_new_slope,
  output logic signed [spt_pkg::WEIGHT_BITS-1:0]  res_new_offset,
  output logic [spt_pkg::MAX_OUT_BITS-1:0]        res_sample_max_update,
  output logic                                    res_sample_done,
  output logic                                    res_converged
);

  localparam int AW  = (MAX_CLASSIFIERS > 1) ? $clog2(MAX_CLASSIFIERS) : 1;
  localparam int WB  = spt_pkg::WEIGHT_BITS;
  localparam int FB  = spt_pkg::FEATURE_BITS;
  localparam int RB  = spt_pkg::RATE_BITS;
  localparam int MO  = spt_pkg::MAX_OUT_BITS;
  localparam int LO  = WB / 2;
  localparam int HI  = WB - LO;
  localparam int PHW = HI + FB;
  localparam int PLW = LO + 1 + FB;
  localparam int PB  = WB + FB;
  localparam int SB  = PB + 1;
  localparam int UB  = RB + FB;      // 2*rate*|x| always fits here
  localparam int EB  = ((WB > UB) ? WB : UB) + 2;

  function automatic logic [WB-1:0] clamp(input logic signed [EB-1:0] r);
    logic [WB-1:0] res;
    if (r[EB-1:WB-1] == '0 || r[EB-1:WB-1] == '1) begin
      res = r[WB-1:0];
    end else if (r[EB-1]) begin
      res = {1'b1, {(WB-1){1'b0}}};
    end else begin
      res = {1'b0, {(WB-1){1'b1}}};
    end
    return res;
  endfunction

  spt_pkg::back_state_t state_r, state_nxt;

  // weight table: {slope, offset}
  logic [2*WB-1:0] mem [0:MAX_CLASSIFIERS-1];
  logic [2*WB-1:0] rd_data_r;
  logic            mem_we;
  logic [AW-1:0]   mem_wa;
  logic [2*WB-1:0] mem_wd;

  logic            clearing_r;
  logic [AW-1:0]   clr_cnt_r;

  spt_pkg::item_t         item_r;
  logic signed [WB-1:0]   w1_r, w2_r, w1n_r, w2n_r;
  logic signed [PHW-1:0]  ph_r;
  logic signed [PLW-1:0]  pl_r;
  logic [UB-1:0]          u1_r;
  logic signed [PB-1:0]   p_r;
  logic                   hpos_r, upd_r;
  logic [UB-1:0]          rmax_r, rmax_nxt;
  logic                   stopped_r, stopped_nxt;

  logic                   out_valid_r, out_pred_r, out_done_r, out_conv_r;
  logic signed [WB-1:0]   out_slope_r, out_offset_r;
  logic [MO-1:0]          out_max_r;

  // multiply stage
  logic signed [FB-1:0]   x;
  logic                   x_neg;
  logic [FB-1:0]          x_mag;
  logic signed [WB-1:0]   rd_w1, rd_w2;
  logic signed [HI-1:0]   wh;
  logic signed [LO:0]     wl;
  logic signed [PHW-1:0]  ph_nxt;
  logic signed [PLW-1:0]  pl_nxt;
  logic [UB-1:0]          rx;

  // sign and update stages
  logic signed [SB-1:0]   s_sum;
  logic                   hpos_nxt, upd_nxt;
  logic                   u1_add;
  logic signed [EB-1:0]   w1_ext, w2_ext, u1_ext, u2_ext, r1, r2;
  logic                   stop_cond;

  // ---------------- control ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spt_pkg::B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    case (state_r)
      spt_pkg::B_IDLE: begin
        if (!q_empty && !clearing_r) begin
          pop       = 1'b1;
          state_nxt = spt_pkg::B_MUL;
        end
      end
      spt_pkg::B_MUL:  state_nxt = spt_pkg::B_SUM;
      spt_pkg::B_SUM:  state_nxt = spt_pkg::B_SIGN;
      spt_pkg::B_SIGN: state_nxt = spt_pkg::B_UPD;
      spt_pkg::B_UPD:  state_nxt = spt_pkg::B_FIN;
      spt_pkg::B_FIN:  state_nxt = spt_pkg::B_IDLE;
      default:         state_nxt = spt_pkg::B_IDLE;
    endcase
  end

  // ---------------- table init sweep ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clearing_r) begin
      if (clr_cnt_r == AW'(MAX_CLASSIFIERS - 1)) begin
        clearing_r <= 1'b0;
      end
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // ---------------- table ----------------
  assign mem_we = clearing_r | ((state_r == spt_pkg::B_FIN) & upd_r);
  assign mem_wa = clearing_r ? clr_cnt_r : AW'(item_r.idx);
  assign mem_wd = clearing_r ? {spt_pkg::SLOPE_RESET, {WB{1'b0}}} : {w1n_r, w2n_r};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rd_data_r <= mem[AW'(head.idx)];
    end
  end

  // ---------------- datapath ----------------
  always_comb begin
    x      = $signed(item_r.feature);
    x_neg  = x[FB-1];
    x_mag  = x_neg ? (~x + 1'b1) : x;
    rd_w1  = $signed(rd_data_r[2*WB-1:WB]);
    rd_w2  = $signed(rd_data_r[WB-1:0]);
    wh     = $signed(rd_w1[WB-1:LO]);
    wl     = $signed({1'b0, rd_w1[LO-1:0]});
    ph_nxt = wh * x;
    pl_nxt = wl * x;
    rx     = learning_rate * x_mag;
  end

  always_comb begin
    s_sum    = SB'(p_r) + SB'(w2_r);
    hpos_nxt = ~s_sum[SB-1];
    upd_nxt  = item_r.in_use & ~stopped_r & (hpos_nxt != item_r.label);
  end

  // slope moves by 2*rate*|x|, offset by 2*rate; direction from prediction (and sign of x for slope)
  always_comb begin
    u1_add = (~hpos_r) != item_r.feature[FB-1];
    w1_ext = EB'(w1_r);
    w2_ext = EB'(w2_r);
    u1_ext = $signed(EB'(u1_r));
    u2_ext = $signed(EB'({learning_rate, 1'b0}));
    r1     = u1_add  ? (w1_ext + u1_ext) : (w1_ext - u1_ext);
    r2     = !hpos_r ? (w2_ext + u2_ext) : (w2_ext - u2_ext);
  end

  always_ff @(posedge clk) begin
    case (state_r)
      spt_pkg::B_IDLE: begin
        if (pop) begin
          item_r <= head;
        end
      end
      spt_pkg::B_MUL: begin
        w1_r <= rd_w1;
        w2_r <= rd_w2;
        ph_r <= ph_nxt;
        pl_r <= pl_nxt;
        u1_r <= rx << 1;
      end
      spt_pkg::B_SUM: begin
        p_r <= $signed({ph_r, {LO{1'b0}}}) + PB'(pl_r);
      end
      spt_pkg::B_SIGN: begin
        hpos_r <= hpos_nxt;
        upd_r  <= upd_nxt;
      end
      spt_pkg::B_UPD: begin
        w1n_r <= upd_r ? $signed(clamp(r1)) : w1_r;
        w2n_r <= upd_r ? $signed(clamp(r2)) : w2_r;
      end
      default: ;
    endcase
  end

  // ---------------- sample tracking ----------------
  assign stop_cond = ~stopped_r && (rmax_r != '0) && (rmax_r < UB'(stop_threshold));

  always_comb begin
    rmax_nxt    = rmax_r;
    stopped_nxt = stopped_r;
    case (state_r)
      spt_pkg::B_UPD: begin
        if (upd_r && (u1_r > rmax_r)) begin
          rmax_nxt = u1_r;
        end
      end
      spt_pkg::B_FIN: begin
        if (item_r.last) begin
          stopped_nxt = stopped_r | stop_cond;
          if (!(stopped_r | stop_cond)) begin
            rmax_nxt = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rmax_r    <= '0;
      stopped_r <= 1'b0;
    end else begin
      rmax_r    <= rmax_nxt;
      stopped_r <= stopped_nxt;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == spt_pkg::B_FIN);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == spt_pkg::B_FIN) begin
      out_pred_r   <= item_r.in_use & hpos_r;
      out_slope_r  <= item_r.in_use ? w1n_r : '0;
      out_offset_r <= item_r.in_use ? w2n_r : '0;
      out_max_r    <= (|rmax_r[UB-1:MO]) ? {MO{1'b1}} : rmax_r[MO-1:0];
      out_done_r   <= item_r.last;
      out_conv_r   <= stopped_nxt;
    end
  end

  assign res_valid             = out_valid_r;
  assign res_prediction        = out_pred_r;
  assign res_new_slope         = out_slope_r;
  assign res_new_offset        = out_offset_r;
  assign res_sample_max_update = out_max_r;
  assign res_sample_done       = out_done_r;
  assign res_converged         = out_conv_r;

  assign status.clearing = clearing_r;
  assign status.stopped  = stopped_r;

endmodule

### design/stump_perceptron_trainer.sv
// Items wait in a 2-deep queue; the back end pops one at a time and runs it through table read,
//   multiply, sum, sign test, update and write-back before popping the next.
// The result strobe comes from the write-back state; start is taken while the queue has room.
// The result strobe lasts one cycle; the receiver cannot stall it.
// Reset (rst_n low, synchronous): clears control state, loads register defaults, then runs a
//   table init over all MAX_CLASSIFIERS entries (busy high, config writes still taken).
module stump_perceptron_trainer #(
  parameter int MAX_CLASSIFIERS = spt_pkg::MAX_CLASSIFIERS
) (
  input  logic                                    clk,
  input  logic                                    rst_n,

  // item channel
  input  logic                                    start,
  output logic                                    busy,
  input  logic [spt_pkg::INDEX_BITS-1:0]          in_classifier_index,
  input  logic signed [spt_pkg::FEATURE_BITS-1:0] in_feature_value,
  input  logic                                    in_sample_label,
  input  logic                                    in_last_of_sample,

  // result channel
  output logic                                    out_valid,
  output logic                                    out_prediction,
  output logic signed [spt_pkg::WEIGHT_BITS-1:0]  out_new_slope,
  output logic signed [spt_pkg::WEIGHT_BITS-1:0]  out_new_offset,
  output logic [spt_pkg::MAX_OUT_BITS-1:0]        out_sample_max_update,
  output logic                                    out_sample_done,
  output logic                                    out_converged,

  // configuration write port
  input  logic                                    cfg_we,
  input  logic [spt_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
  input  logic [spt_pkg::CFG_DATA_BITS-1:0]       cfg_wdata
);

  // Config registers. The user keeps them only written while the block is idle (the block does
  // not enforce it), so the front (count) and back (rate, threshold) read them directly.
  logic [spt_pkg::RATE_BITS-1:0]   learning_rate_r;
  logic [spt_pkg::THRESH_BITS-1:0] stop_threshold_r;
  logic [spt_pkg::COUNT_BITS-1:0]  classifier_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      learning_rate_r    <= spt_pkg::RATE_RESET;
      stop_threshold_r   <= spt_pkg::THRESH_RESET;
      classifier_count_r <= spt_pkg::COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        spt_pkg::CFG_LEARNING_RATE:    learning_rate_r    <= cfg_wdata[spt_pkg::RATE_BITS-1:0];
        spt_pkg::CFG_STOP_THRESHOLD:   stop_threshold_r   <= cfg_wdata[spt_pkg::THRESH_BITS-1:0];
        spt_pkg::CFG_CLASSIFIER_COUNT: classifier_count_r <= cfg_wdata[spt_pkg::COUNT_BITS-1:0];
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  spt_pkg::item_t        head;
  logic                  q_empty;
  logic                  pop;
  spt_pkg::back_status_t status;

  // Front end: takes items, flags entries outside the live range, and
  // parks them in a 2-deep queue. busy covers table init and a full queue.
  spt_front #(
    .MAX_CLASSIFIERS (MAX_CLASSIFIERS)
  ) u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_classifier_index (in_classifier_index),
    .in_feature_value    (in_feature_value),
    .in_sample_label     (in_sample_label),
    .in_last_of_sample   (in_last_of_sample),
    .classifier_count    (classifier_count_r),
    .table_busy          (status.clearing),
    .pop                 (pop),
    .head                (head),
    .q_empty             (q_empty)
  );

  // Back end: one item at a time through read, multiply, product sum,
  // sign test, saturating update, write-back. The write lands before the
  // next read, so back-to-back hits on one entry need no forwarding.
  spt_back #(
    .MAX_CLASSIFIERS (MAX_CLASSIFIERS)
  ) u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .head                  (head),
    .q_empty               (q_empty),
    .pop                   (pop),
    .learning_rate         (learning_rate_r),
    .stop_threshold        (stop_threshold_r),
    .status                (status),
    .res_valid             (out_valid),
    .res_prediction        (out_prediction),
    .res_new_slope         (out_new_slope),
    .res_new_offset        (out_new_offset),
    .res_sample_max_update (out_sample_max_update),
    .res_sample_done       (out_sample_done),
    .res_converged         (out_converged)
  );

  // Each item passes through every back-end state before the next is popped, so two strobes never touch.
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  // Once converged, training stays frozen until reset.
  a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    status.stopped |=> status.stopped)
    else $error("stop flag dropped without reset");

  // No item runs while the table is being initialized.
  a_quiet_init: assert property (@(posedge clk) disable iff (!rst_n)
    status.clearing |-> !out_valid && !pop)
    else $error("item activity during table init");

endmodule
